### hdl/albp_pkg.sv
`default_nettype none

package albp_pkg;

  // Result codes reported on the event_res field.
  localparam logic [2:0] EV_DATA    = 3'd0;
  localparam logic [2:0] EV_OK      = 3'd1;
  localparam logic [2:0] EV_BADSUM  = 3'd2;
  localparam logic [2:0] EV_START   = 3'd3;
  localparam logic [2:0] EV_NOSTART = 3'd4;
  localparam logic [2:0] EV_HDRERR  = 3'd5;
  localparam logic [2:0] EV_LENERR  = 3'd6;

  // Header, length and address bytes counted in a block's length word.
  localparam logic [15:0] OVERHEAD = 16'd6;

  // Low byte of the block header word.
  localparam logic [7:0] HEADER_LO = 8'h01;

  // One result request from the parser toward the output register.
  typedef struct packed {
    logic        valid;
    logic [2:0]  event_res;
    logic [15:0] address;
    logic [7:0]  value;
  } result_t;

endpackage

`default_nettype wire

### hdl/absolute_loader_block_parser.sv
// Absolute-loader block stream parser.
//
// Input channel: in_valid, in_stall, in_byte carry one raw stream byte per
// request. Output channel: out_valid, out_stall, event_res, address, value
// carry at most one result per input byte (data byte, block ok, bad
// checksum, start address, end without start, header error, length error).
//
// Throughput is one byte per cycle while the receiver does not stall. A
// byte is captured in the input register and decoded against the parser
// state in the following cycle; its result enters the output register
// when the parser takes the byte. Bytes that give no result (zero fill,
// header, length and address bytes) only update the parser state.
//
// Reset (rst, synchronous) empties both registers and puts the parser back
// to hunting for a block header. When the receiver stalls, the output
// register holds its result, the input register holds one more byte, and
// in_stall then rises until the output drains.
`default_nettype none

module absolute_loader_block_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       event_res,
  output logic [15:0]      address,
  output logic [7:0]       value
);

  logic              advance;
  logic              held_valid;
  logic [7:0]        held_byte;
  albp_pkg::result_t result;

  albp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  albp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (held_valid && advance),
    .data_byte (held_byte),
    .result    (result)
  );

  albp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .address   (address),
    .value     (value)
  );

endmodule

`default_nettype wire

### hdl/albp_in_stage.sv
`default_nettype none

module albp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       advance,
  output logic            held_valid,
  output logic [7:0]      held_byte
);

  // The held byte can be replaced only when the parser takes it this cycle.
  assign in_stall = held_valid && !advance;

  // Input register: loads a new request whenever the channel is not stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      held_byte <= in_byte;
    end
  end

endmodule

`default_nettype wire

### hdl/albp_parser.sv
`default_nettype none

module albp_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  output albp_pkg::result_t result
);

  typedef enum logic [7:0] {
    PH_HUNT   = 8'b0000_0001,
    PH_HDR_HI = 8'b0000_0010,
    PH_LEN_LO = 8'b0000_0100,
    PH_LEN_HI = 8'b0000_1000,
    PH_ADR_LO = 8'b0001_0000,
    PH_ADR_HI = 8'b0010_0000,
    PH_DATA   = 8'b0100_0000,
    PH_CKSUM  = 8'b1000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] load_address, load_address_next;
  logic [15:0] block_start, block_start_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;

  logic [7:0]  sum_add;
  logic [15:0] word;

  assign sum_add = running_sum + data_byte;
  assign word    = {data_byte, low_byte_hold};

  // Next state and result for the byte held in the input register.
  always_comb begin
    phase_next         = phase;
    running_sum_next   = sum_add;
    bytes_left_next    = bytes_left;
    load_address_next  = load_address;
    block_start_next   = block_start;
    low_byte_hold_next = low_byte_hold;
    result             = '0;

    case (phase)
      PH_HUNT: begin
        running_sum_next = running_sum;
        if (data_byte != 8'd0) begin
          running_sum_next   = data_byte;
          low_byte_hold_next = data_byte;
          phase_next         = PH_HDR_HI;
        end
      end
      PH_HDR_HI: begin
        if (low_byte_hold != albp_pkg::HEADER_LO) begin
          phase_next       = PH_HUNT;
          result.valid     = 1'b1;
          result.event_res = albp_pkg::EV_HDRERR;
          result.value     = low_byte_hold;
        end else if (data_byte != 8'd0) begin
          phase_next       = PH_HUNT;
          result.valid     = 1'b1;
          result.event_res = albp_pkg::EV_HDRERR;
          result.value     = data_byte;
        end else begin
          phase_next = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        low_byte_hold_next = data_byte;
        phase_next         = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        bytes_left_next = word;
        phase_next      = PH_ADR_LO;
      end
      PH_ADR_LO: begin
        low_byte_hold_next = data_byte;
        phase_next         = PH_ADR_HI;
      end
      PH_ADR_HI: begin
        load_address_next = word;
        block_start_next  = word;
        phase_next        = PH_HUNT;
        if (bytes_left < albp_pkg::OVERHEAD) begin
          result.valid     = 1'b1;
          result.event_res = albp_pkg::EV_LENERR;
          result.address   = word;
        end else if (bytes_left == albp_pkg::OVERHEAD) begin
          result.valid = 1'b1;
          if (!word[0]) begin
            result.event_res = albp_pkg::EV_START;
            result.address   = word;
          end else begin
            result.event_res = albp_pkg::EV_NOSTART;
          end
        end else begin
          bytes_left_next = bytes_left - albp_pkg::OVERHEAD;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        load_address_next = load_address + 16'd1;
        bytes_left_next   = bytes_left - 16'd1;
        if (bytes_left == 16'd1) begin
          phase_next = PH_CKSUM;
        end
        result.valid     = 1'b1;
        result.event_res = albp_pkg::EV_DATA;
        result.address   = load_address;
        result.value     = data_byte;
      end
      PH_CKSUM: begin
        phase_next       = PH_HUNT;
        result.valid     = 1'b1;
        result.event_res = (sum_add == 8'd0) ? albp_pkg::EV_OK : albp_pkg::EV_BADSUM;
        result.address   = block_start;
        result.value     = data_byte;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    if (!fire) begin
      result.valid = 1'b0;
    end
  end

  // Parser state advances only when a byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      running_sum   <= 8'd0;
      bytes_left    <= 16'd0;
      load_address  <= 16'd0;
      block_start   <= 16'd0;
      low_byte_hold <= 8'd0;
    end else if (fire) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      bytes_left    <= bytes_left_next;
      load_address  <= load_address_next;
      block_start   <= block_start_next;
      low_byte_hold <= low_byte_hold_next;
    end
  end

endmodule

`default_nettype wire

### hdl/albp_out_stage.sv
`default_nettype none

module albp_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire albp_pkg::result_t result,
  output logic                   advance,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             event_res,
  output logic [15:0]            address,
  output logic [7:0]             value
);

  // The register can take a new result when it is empty or being drained.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.valid;
    end
  end

  // Payload loads only with a valid result, so a stalled request holds.
  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      event_res <= result.event_res;
      address   <= result.address;
      value     <= result.value;
    end
  end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;

  // Parser phases of the block format, as tracked by the prediction.
  typedef enum logic [7:0] {
    P_SEEK   = 8'b0000_0001,
    P_HDR_HI = 8'b0000_0010,
    P_LEN_LO = 8'b0000_0100,
    P_LEN_HI = 8'b0000_1000,
    P_ADR_LO = 8'b0001_0000,
    P_ADR_HI = 8'b0010_0000,
    P_DATA   = 8'b0100_0000,
    P_CKSUM  = 8'b1000_0000
  } parse_phase_t;

  typedef struct {
    logic [2:0]  ev;
    logic [15:0] addr;
    logic [7:0]  val;
  } loader_result_t;

  // One entry of the stream: a byte, or a marker to wait for all results.
  typedef struct {
    bit         pause;
    logic [7:0] data;
  } stream_entry_t;

  localparam int ITEM_TARGET = 850;
  localparam int DRAIN_CYCLES = 20;
  localparam int LONG_HOLD = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  event_res;
  logic [15:0] address;
  logic [7:0]  value;

  stream_entry_t  stream_bytes[$];
  loader_result_t pending_results[$];
  int failures = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int gap_left = 0;
  int hold_left = 0;
  int long_left = 0;

  // Prediction state.
  parse_phase_t parse_phase = P_SEEK;
  logic [7:0]   block_sum = 8'h00;
  logic [15:0]  payload_left = 16'h0000;
  logic [15:0]  next_addr = 16'h0000;
  logic [15:0]  block_addr = 16'h0000;
  logic [7:0]   held_byte = 8'h00;

  absolute_loader_block_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .event_res (event_res),
    .address   (address),
    .value     (value)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait(input bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic note_result(input logic [2:0] ev, input logic [15:0] addr,
                             input logic [7:0] val);
    loader_result_t r;
    r.ev = ev;
    r.addr = addr;
    r.val = val;
    pending_results.push_back(r);
  endtask

  // Advance the parser by one accepted byte and record any result it gives.
  task automatic parse_byte(input logic [7:0] b);
    logic [15:0] word;
    word = {b, held_byte};
    if (parse_phase == P_SEEK) begin
      // Zero fill is skipped; a nonzero byte opens a header pair.
      if (b != 8'h00) begin
        block_sum = b;
        held_byte = b;
        parse_phase = P_HDR_HI;
      end
    end else begin
      block_sum = block_sum + b;
      case (parse_phase)
        P_HDR_HI: begin
          parse_phase = P_SEEK;
          if (held_byte != albp_pkg::HEADER_LO) begin
            note_result(albp_pkg::EV_HDRERR, 16'h0000, held_byte);
          end else if (b != 8'h00) begin
            note_result(albp_pkg::EV_HDRERR, 16'h0000, b);
          end else begin
            parse_phase = P_LEN_LO;
          end
        end
        P_LEN_LO: begin
          held_byte = b;
          parse_phase = P_LEN_HI;
        end
        P_LEN_HI: begin
          payload_left = word;
          parse_phase = P_ADR_LO;
        end
        P_ADR_LO: begin
          held_byte = b;
          parse_phase = P_ADR_HI;
        end
        P_ADR_HI: begin
          next_addr = word;
          block_addr = word;
          parse_phase = P_SEEK;
          if (payload_left < albp_pkg::OVERHEAD) begin
            note_result(albp_pkg::EV_LENERR, word, 8'h00);
          end else if (payload_left == albp_pkg::OVERHEAD) begin
            // End block: an even address is the start address.
            if (!word[0]) begin
              note_result(albp_pkg::EV_START, word, 8'h00);
            end else begin
              note_result(albp_pkg::EV_NOSTART, 16'h0000, 8'h00);
            end
          end else begin
            payload_left = payload_left - albp_pkg::OVERHEAD;
            parse_phase = P_DATA;
          end
        end
        P_DATA: begin
          note_result(albp_pkg::EV_DATA, next_addr, b);
          next_addr = next_addr + 16'd1;
          payload_left = payload_left - 16'd1;
          if (payload_left == 16'h0000) begin
            parse_phase = P_CKSUM;
          end
        end
        default: begin
          parse_phase = P_SEEK;
          note_result((block_sum == 8'h00) ? albp_pkg::EV_OK : albp_pkg::EV_BADSUM,
                      block_addr, b);
        end
      endcase
    end
  endtask

  task automatic add_byte(input logic [7:0] b);
    stream_entry_t e;
    e.pause = 1'b0;
    e.data = b;
    stream_bytes.push_back(e);
  endtask

  task automatic add_pause();
    stream_entry_t e;
    e.pause = 1'b1;
    e.data = 8'h00;
    stream_bytes.push_back(e);
  endtask

  // Header word, length word and address word; returns their byte sum.
  task automatic add_head(input logic [15:0] len, input logic [15:0] addr,
                          output logic [7:0] sum);
    add_byte(albp_pkg::HEADER_LO);
    add_byte(8'h00);
    add_byte(len[7:0]);
    add_byte(len[15:8]);
    add_byte(addr[7:0]);
    add_byte(addr[15:8]);
    sum = albp_pkg::HEADER_LO + len[7:0] + len[15:8] + addr[7:0] + addr[15:8];
  endtask

  // A data block of n random bytes, with a correct or a damaged checksum.
  task automatic add_block(input int n, input logic [15:0] addr, input bit corrupt);
    logic [7:0] sum;
    logic [7:0] d;
    add_head(16'(n) + albp_pkg::OVERHEAD, addr, sum);
    repeat (n) begin
      d = 8'($urandom_range(0, 255));
      add_byte(d);
      sum = sum + d;
    end
    d = 8'h00 - sum;
    if (corrupt) begin
      d = d + 8'($urandom_range(1, 255));
    end
    add_byte(d);
  endtask

  // Sender: one request per stream byte, with a drawn gap before the next.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(in_byte);
        bytes_sent++;
        gap_left = draw_wait((bytes_sent / 128) % 3 == 2);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (stream_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (stream_bytes[0].pause) begin
          // Hold back until every outstanding result has been checked.
          in_valid <= 1'b0;
          if (pending_results.size() == 0) begin
            void'(stream_bytes.pop_front());
          end
        end else begin
          in_byte <= stream_bytes[0].data;
          in_valid <= 1'b1;
          void'(stream_bytes.pop_front());
        end
      end
    end
  end

  // Receiver: check each result request, then stall for a drawn time.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      long_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: event_res=%0d address=%h value=%h",
                 event_res, address, value);
          failures++;
        end else begin
          loader_result_t want;
          want = pending_results.pop_front();
          if (event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, event_res);
            failures++;
          end
          if (address !== want.addr) begin
            $error("address: expected %h, got %h", want.addr, address);
            failures++;
          end
          if (value !== want.val) begin
            $error("value: expected %h, got %h", want.val, value);
            failures++;
          end
        end
        results_seen++;
        hold_left = draw_wait((results_seen / 100) % 3 == 1);
        // A long hold-off lets the block fill up and stall its input.
        if (results_seen == 60 || results_seen == 250) begin
          long_left = LONG_HOLD;
        end
      end
      if (long_left > 0) begin
        long_left--;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of the run.
  initial begin
    int pick;
    int n;
    logic [15:0] addr;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] unused_sum;

    // Directed: zero fill, both kinds of bad header, a short length,
    // a block that wraps the address, and an end block with a start.
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(albp_pkg::HEADER_LO);
    add_byte(8'h80);
    add_head(16'h0000, 16'hFFFF, unused_sum);
    add_block(2, 16'hFFFF, 1'b0);
    add_head(albp_pkg::OVERHEAD, 16'h0000, unused_sum);
    add_pause();

    // Random: mostly well-formed blocks, with broken headers and noise.
    while (stream_bytes.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      addr = ($urandom_range(0, 9) == 0) ? 16'hFFFF - 16'($urandom_range(0, 8))
                                         : 16'($urandom());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) add_byte(8'h00);
      end
      if (pick < 60) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        add_block(n, addr, $urandom_range(0, 4) == 0);
      end else if (pick < 70) begin
        add_head(albp_pkg::OVERHEAD, addr, unused_sum);
      end else if (pick < 76) begin
        add_head(16'($urandom_range(0, 5)), addr, unused_sum);
      end else if (pick < 86) begin
        b0 = 8'($urandom_range(1, 255));
        b1 = (b0 == albp_pkg::HEADER_LO) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(0, 255));
        add_byte(b0);
        add_byte(b1);
      end else if (pick < 97) begin
        repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        add_pause();
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (stream_bytes.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
